// ----- rtl/core/kfq_pkg.sv -----
// Package for the keyed FIFO queue unit: request and status codes,
// field widths and the record type held in the slot memory.
// Depends on nothing; imported by keyed_fifo_queue_unit and its testbench.
package kfq_pkg;

  localparam int CODE_W    = 31;
  localparam int PAYLOAD_W = 64;
  localparam int COUNT_W   = 5;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ENQ    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // One record as stored in a slot.
  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

endpackage

// ----- rtl/core/keyed_fifo_queue_unit.sv -----
// Keyed FIFO queue unit: a bounded circular queue of records kept in one
// synchronous slot memory, with enqueue, dequeue, search and delete by code.
// Depends on kfq_pkg.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   req_type selects enqueue, dequeue, search or delete; item_code is the
//   key and item_payload the data stored on enqueue.
//   Exactly one result follows each request. It is shown for one cycle with
//   done high: status, out_code, out_payload and entry_count (records held
//   after the request, modulo 32). The receiver cannot stall the result.
// Sequence from accept to done:
//   enqueue: done in the cycle after the accept; dequeue: the head slot is
//   read and returned in S_DEQ; search and delete on a non-empty queue: S_WALK
//   reads one slot per cycle through the single read port, one per held record;
//   on an empty queue, as for enqueue. busy is low again in the done cycle, so
//   a new request can be taken then.
// Reset:
//   rst clears the queue to empty and returns to idle. Slot contents are
//   not cleared; only slots that hold records are ever read.
module keyed_fifo_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [kfq_pkg::REQ_W-1:0]      req_type,
  input  logic [kfq_pkg::CODE_W-1:0]     item_code,
  input  logic [kfq_pkg::PAYLOAD_W-1:0]  item_payload,
  output logic                           done,
  output logic [kfq_pkg::STATUS_W-1:0]   status,
  output logic [kfq_pkg::CODE_W-1:0]     out_code,
  output logic [kfq_pkg::PAYLOAD_W-1:0]  out_payload,
  output logic [kfq_pkg::COUNT_W-1:0]    entry_count
);
  import kfq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEQ  = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] kept, kept_next;
  logic [REQ_W-1:0] req, req_next;
  logic [CODE_W-1:0] key, key_next;
  entry_t hit, hit_next;
  logic hit_found, hit_found_next;
  logic done_next;
  logic [STATUS_W-1:0] status_next;
  logic [CODE_W-1:0] out_code_next;
  logic [PAYLOAD_W-1:0] out_payload_next;

  // Slot memory port signals.
  entry_t mem [DEPTH];
  entry_t rd_data, wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic rd_en, we;
  logic match, last;

  // Slot of the record at a given offset behind base, wrapped once.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = (AW + 1)'(base) + (AW + 1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign busy        = (state != S_IDLE);
  assign entry_count = COUNT_W'(count);
  assign match       = (rd_data.code == key);
  assign last        = (idx == count - 1'b1);

  // Request sequencing, memory access and result formation.
  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    idx_next         = idx;
    kept_next        = kept;
    req_next         = req;
    key_next         = key;
    hit_next         = hit;
    hit_found_next   = hit_found;
    done_next        = 1'b0;
    status_next      = ST_OK;
    out_code_next    = '0;
    out_payload_next = '0;
    rd_en            = 1'b0;
    rd_addr          = head;
    we               = 1'b0;
    wr_addr          = slot_of(head, count);
    wr_data          = '{code: item_code, payload: item_payload};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next = req_type;
          key_next = item_code;
          unique case (req_type) inside
            REQ_ENQ: begin
              done_next = 1'b1;
              if (count == FULL_C) begin
                status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + 1'b1;
              end
            end
            REQ_DEQ: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                state_next = S_DEQ;
              end
            end
            REQ_SEARCH, REQ_DELETE: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = (req_type == REQ_SEARCH) ? ST_NOT_FOUND : ST_OK;
              end else begin
                rd_en          = 1'b1;
                idx_next       = '0;
                kept_next      = '0;
                hit_found_next = 1'b0;
                state_next     = S_WALK;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_DEQ: begin
        // Head record arrives from memory this cycle.
        done_next        = 1'b1;
        out_code_next    = rd_data.code;
        out_payload_next = rd_data.payload;
        head_next        = slot_of(head, CW'(1));
        count_next       = count - 1'b1;
        state_next       = S_IDLE;
      end
      S_WALK: begin
        // Search keeps the latest match; delete packs survivors behind head.
        if (req == REQ_SEARCH && match) begin
          hit_next       = rd_data;
          hit_found_next = 1'b1;
        end
        if (req == REQ_DELETE && !match) begin
          we        = 1'b1;
          wr_addr   = slot_of(head, kept);
          wr_data   = rd_data;
          kept_next = kept + 1'b1;
        end
        if (last) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (req == REQ_SEARCH) begin
            if (hit_found_next) begin
              out_code_next    = hit_next.code;
              out_payload_next = hit_next.payload;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end else begin
            count_next = kept_next;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = slot_of(head, idx + 1'b1);
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    kept        <= kept_next;
    req         <= req_next;
    key         <= key_next;
    hit         <= hit_next;
    hit_found   <= hit_found_next;
    status      <= status_next;
    out_code    <= out_code_next;
    out_payload <= out_payload_next;
  end

  // The queue never holds more than DEPTH records.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_C)
    else $error("record count above depth");

  // A walk never looks at an index beyond the held records.
  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> idx < count)
    else $error("walk index beyond held records");

  // Every result follows an accepted request or ongoing work.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a request");

  // A successful dequeue removes exactly one record.
  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DEQ |=> count == $past(count) - 1'b1)
    else $error("dequeue did not remove one record");

  // An enqueue never writes into a full queue.
  a_enq_room: assert property (@(posedge clk) disable iff (rst)
    (we && state == S_IDLE) |-> count < FULL_C)
    else $error("write into a full queue");

endmodule

// ----- sim/keyed_fifo_queue_unit_test.sv -----
// Testbench for the keyed FIFO queue unit: directed and random requests,
// with a scoreboard class that predicts every result and checks it.
// Depends on kfq_pkg and keyed_fifo_queue_unit.
module keyed_fifo_queue_unit_test;
  import kfq_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 217;
  localparam int SHOWN_MAX   = 10;

  // Fields of one result as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CODE_W-1:0]    code;
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   count;
  } outcome_t;

  // Scoreboard: keeps its own copy of the queue, works out the result of
  // each accepted item and compares it with the next result from the block.
  class queue_scoreboard;
    entry_t   model_records[$];
    outcome_t pending_results[$];
    int       failures;
    int       mismatches;
    int       req_seen[4];
    int       full_seen;
    int       empty_seen;
    int       miss_seen;

    function new();
      failures   = 0;
      mismatches = 0;
      full_seen  = 0;
      empty_seen = 0;
      miss_seen  = 0;
      foreach (req_seen[i]) req_seen[i] = 0;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // Apply one accepted item to the queue copy and queue its result.
    function void apply_request(logic [REQ_W-1:0] req, logic [CODE_W-1:0] code,
                                logic [PAYLOAD_W-1:0] payload);
      outcome_t r;
      entry_t   e;
      entry_t   kept[$];
      r        = '0;
      r.status = ST_OK;
      req_seen[req]++;
      case (req)
        REQ_ENQ: begin
          if (model_records.size() >= QDEPTH) begin
            r.status = ST_FULL;
            full_seen++;
          end else begin
            e.code    = code;
            e.payload = payload;
            model_records.push_back(e);
          end
        end
        REQ_DEQ: begin
          if (model_records.size() == 0) begin
            r.status = ST_EMPTY;
            empty_seen++;
          end else begin
            e         = model_records.pop_front();
            r.code    = e.code;
            r.payload = e.payload;
          end
        end
        REQ_SEARCH: begin
          // The most recent match wins, so keep overwriting while walking.
          r.status = ST_NOT_FOUND;
          foreach (model_records[i]) begin
            if (model_records[i].code == code) begin
              r.status  = ST_OK;
              r.code    = model_records[i].code;
              r.payload = model_records[i].payload;
            end
          end
          if (r.status == ST_NOT_FOUND) miss_seen++;
        end
        default: begin
          // Delete keeps the order of every record that does not match.
          foreach (model_records[i]) begin
            if (model_records[i].code != code) kept.push_back(model_records[i]);
          end
          model_records = kept;
        end
      endcase
      r.count = COUNT_W'(model_records.size());
      pending_results.push_back(r);
    endfunction

    // Compare one result from the block with the oldest expectation.
    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("unexpected result: status=%0d code=%h payload=%h count=%0d",
                   got.status, got.code, got.payload, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (want.status != got.status || want.code != got.code ||
          want.payload != got.payload || want.count != got.count) begin
        failures++;
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display({"mismatch: expected status=%0d code=%h payload=%h count=%0d,",
                    " got status=%0d code=%h payload=%h count=%0d"},
                   want.status, want.code, want.payload, want.count,
                   got.status, got.code, got.payload, got.count);
      end
    endfunction

    // Expectations still waiting at the end are failures.
    function void close_out();
      if (pending_results.size() != 0) begin
        failures += pending_results.size();
        $display("%0d expected results never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [REQ_W-1:0]     req_type     = REQ_ENQ;
  logic [CODE_W-1:0]    item_code    = '0;
  logic [PAYLOAD_W-1:0] item_payload = '0;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [CODE_W-1:0]    out_code;
  logic [PAYLOAD_W-1:0] out_payload;
  logic [COUNT_W-1:0]   entry_count;

  queue_scoreboard sb;
  int              cycles     = 0;
  int              burst_left = 0;

  keyed_fifo_queue_unit #(.DEPTH(QDEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .item_code    (item_code),
    .item_payload (item_payload),
    .done         (done),
    .status       (status),
    .out_code     (out_code),
    .out_payload  (out_payload),
    .entry_count  (entry_count)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Monitor: results first, then the item accepted at this edge.
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (done) sb.check_result({status, out_code, out_payload, entry_count});
      if (start && !busy) sb.apply_request(req_type, item_code, item_payload);
    end
  end

  // Present one item after a random gap and hold it until it is taken.
  // Runs of items with no gap are mixed in.
  task automatic send_item(logic [REQ_W-1:0] req, logic [CODE_W-1:0] code,
                           logic [PAYLOAD_W-1:0] payload);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    req_type     <= req;
    item_code    <= code;
    item_payload <= payload;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // Mostly a small pool of keys so that searches and deletes hit often.
  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 9))
      7:       return {CODE_W{1'b1}};
      8:       return '0;
      9:       return CODE_W'($urandom);
      default: return CODE_W'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return {PAYLOAD_W{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Request mix per phase: fill-heavy, drain-heavy or balanced.
  function automatic logic [REQ_W-1:0] pick_req(int mode);
    int r;
    int enq_lim;
    int deq_lim;
    r = $urandom_range(0, 99);
    case (mode)
      0:       begin enq_lim = 60; deq_lim = 70; end
      1:       begin enq_lim = 25; deq_lim = 60; end
      default: begin enq_lim = 40; deq_lim = 65; end
    endcase
    if (r < enq_lim) return REQ_ENQ;
    if (r < deq_lim) return REQ_DEQ;
    if (r < 88) return REQ_SEARCH;
    return REQ_DELETE;
  endfunction

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue cases, fill to full with repeated keys and
    // extreme values, overflow, then search and delete on a full queue.
    send_item(REQ_DEQ, '0, '0);
    send_item(REQ_SEARCH, CODE_W'(7), '0);
    send_item(REQ_DELETE, CODE_W'(7), '0);
    for (int i = 0; i < QDEPTH; i++) begin
      case (i % 4)
        0:       send_item(REQ_ENQ, '0, (i == 0) ? '0 : pick_payload());
        1:       send_item(REQ_ENQ, {CODE_W{1'b1}},
                           (i == 1) ? {PAYLOAD_W{1'b1}} : pick_payload());
        2:       send_item(REQ_ENQ, CODE_W'(3), pick_payload());
        default: send_item(REQ_ENQ, CODE_W'(i), pick_payload());
      endcase
    end
    send_item(REQ_ENQ, CODE_W'(9), {PAYLOAD_W{1'b1}});
    send_item(REQ_SEARCH, '0, '0);
    send_item(REQ_SEARCH, CODE_W'(31'h1234567), '0);
    send_item(REQ_SEARCH, {CODE_W{1'b1}}, '0);
    send_item(REQ_DELETE, '0, '0);
    send_item(REQ_DEQ, '0, '0);
    drain_results();

    // Random phases, each ending with a full drain of the results.
    for (int p = 0; p < PHASES; p++) begin
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_item(pick_req(p % 3), pick_code(), pick_payload());
      drain_results();
    end

    // Let any stray result show up before closing.
    repeat (QDEPTH + 4) @(posedge clk);
    sb.close_out();

    $display("Requests: %0d enqueue, %0d dequeue, %0d search, %0d delete.",
             sb.req_seen[REQ_ENQ], sb.req_seen[REQ_DEQ],
             sb.req_seen[REQ_SEARCH], sb.req_seen[REQ_DELETE]);
    $display("Overflows %0d, empty dequeues %0d, search misses %0d, failures %0d.",
             sb.full_seen, sb.empty_seen, sb.miss_seen, sb.failures);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/kfq_pkg.sv
rtl/core/keyed_fifo_queue_unit.sv
sim/keyed_fifo_queue_unit_test.sv
